// ===== rtl/byte_ring_buffer_defines.svh =====
// Assertion macros for the byte ring buffer checker.
// Depends on nothing; the including file provides clk_i and rst_ni.
`ifndef BYTE_RING_BUFFER_DEFINES_SVH
`define BYTE_RING_BUFFER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define BRB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/brb_pkg.sv =====
// Shared types and constants of the byte ring buffer.
// Used by the top level and the checker; depends on nothing.
package brb_pkg;

  // Store geometry and burst limit.
  localparam int STORE_DEPTH = 256;
  localparam int MAX_BURST   = 64;

  // Field widths fixed by the interface.
  localparam int REQ_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int BURST_W = 7;
  localparam int CAP_W   = 9;
  localparam int FILL_W  = 9;

  // Internal widths derived from the store depth.
  localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int WIDE_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [BYTE_W-1:0]  data_byte;
    logic [BURST_W-1:0] burst_len;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               byte_valid;
    logic               write_accepted;
    logic [BURST_W-1:0] granted_count;
    logic [FILL_W-1:0]  fill_after;
    logic               last_of_run;
  } result_t;

endpackage

// ===== rtl/brb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/byte_ring_buffer.sv =====
// Byte ring buffer with a programmable capacity and burst reads.
// Depends on brb_pkg and brb_ram.
//
// A write transaction is accepted when start is high and busy is low, and its single
// result appears on the next cycle. A read or peek that grants g bytes holds busy high
// while its bytes are read and delivers one byte per cycle, the first once the sequencer
// has registered the read index and the RAM its read data, the last marked by last_of_run;
// the one read port of the byte RAM sets this rate. A read or peek that
// grants nothing, and an unknown request, give one result on the next cycle like a
// write. Each result is shown for exactly one cycle with result_valid_o and cannot be
// held off by the receiver. There is no clearing pass after reset. The capacity
// register is taken only while the buffer is empty, and head and tail then return to 0.
module byte_ring_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side.
  input  logic                          start,
  output logic                          busy,
  input  brb_pkg::req_t                 req_i,
  // Result side.
  output logic                          result_valid_o,
  output brb_pkg::result_t              result_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brb_pkg::PADDR_W-1:0]   paddr,
  input  logic [brb_pkg::PDATA_W-1:0]   pwdata,
  output logic [brb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int PTR_W   = brb_pkg::PTR_W;
  localparam int CNT_W   = brb_pkg::CNT_W;
  localparam int SUM_W   = brb_pkg::SUM_W;
  localparam int WIDE_W  = brb_pkg::WIDE_W;
  localparam int BURST_W = brb_pkg::BURST_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_BURST = 1'b1;

  logic                        state_q, state_d;
  logic [brb_pkg::CAP_W-1:0]   cap_q, cap_d;
  logic [PTR_W-1:0]            head_q, head_d;
  logic [PTR_W-1:0]            tail_q, tail_d;
  logic [CNT_W-1:0]            fill_q, fill_d;
  logic [PTR_W-1:0]            rd_idx_q, rd_idx_d;
  logic [BURST_W-1:0]          rem_q, rem_d;
  logic [BURST_W-1:0]          grant_q, grant_d;
  logic [CNT_W-1:0]            fill_end_q, fill_end_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_ram_q, out_ram_d;
  brb_pkg::result_t            out_q, out_d;

  logic [CNT_W-1:0]            cap_eff;
  logic                        accept;
  logic                        full;
  logic                        ram_we;
  logic [brb_pkg::BYTE_W-1:0]  ram_rdata;
  logic [BURST_W-1:0]          burst_sat;
  logic [BURST_W-1:0]          grant;
  logic [SUM_W-1:0]            cap_sum;
  logic [SUM_W-1:0]            tail_inc;
  logic [SUM_W-1:0]            rd_inc;
  logic [SUM_W-1:0]            head_adv;
  logic                        cfg_we;

  // Effective capacity: zero acts as one, oversize clamps to the store depth.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (WIDE_W'(cap_q) > WIDE_W'(brb_pkg::STORE_DEPTH)) begin
      cap_eff = CNT_W'(brb_pkg::STORE_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign accept  = start && !busy;
  assign full    = WIDE_W'(fill_q) >= WIDE_W'(cap_eff);
  assign cap_sum = SUM_W'(cap_eff);

  // Burst length saturates at the limit, then at the fill level.
  always_comb begin
    burst_sat = (WIDE_W'(req_i.burst_len) > WIDE_W'(brb_pkg::MAX_BURST)) ?
                BURST_W'(brb_pkg::MAX_BURST) : req_i.burst_len;
    grant = (WIDE_W'(fill_q) < WIDE_W'(burst_sat)) ? BURST_W'(fill_q) : burst_sat;
  end

  // Pointer arithmetic with wrap at the effective capacity.
  always_comb begin
    tail_inc = SUM_W'(tail_q) + SUM_W'(1);
    if (tail_inc >= cap_sum) begin
      tail_inc = '0;
    end
    rd_inc = SUM_W'(rd_idx_q) + SUM_W'(1);
    if (rd_inc >= cap_sum) begin
      rd_inc = '0;
    end
    head_adv = SUM_W'(head_q) + SUM_W'(grant);
    if (head_adv >= cap_sum) begin
      head_adv = head_adv - cap_sum;
    end
  end

  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == brb_pkg::REG_CAPACITY);

  // Sequencer: requests and capacity writes in idle, one RAM read per cycle in a burst.
  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    rem_d       = rem_q;
    grant_d     = grant_q;
    fill_end_d  = fill_end_q;
    out_valid_d = 1'b0;
    out_ram_d   = 1'b0;
    out_d       = out_q;
    ram_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d.read_byte      = '0;
          out_d.byte_valid     = 1'b0;
          out_d.write_accepted = 1'b0;
          out_d.granted_count  = '0;
          out_d.fill_after     = brb_pkg::FILL_W'(fill_q);
          out_d.last_of_run    = 1'b1;
          case (req_i.req_type) inside
            brb_pkg::REQ_WRITE: begin
              out_valid_d = 1'b1;
              if (!full) begin
                ram_we               = 1'b1;
                tail_d               = PTR_W'(tail_inc);
                fill_d               = fill_q + CNT_W'(1);
                out_d.write_accepted = 1'b1;
                out_d.granted_count  = BURST_W'(1);
                out_d.fill_after     = brb_pkg::FILL_W'(fill_q + CNT_W'(1));
              end
            end
            brb_pkg::REQ_READ, brb_pkg::REQ_PEEK: begin
              if (grant == '0) begin
                out_valid_d = 1'b1;
              end else begin
                state_d    = ST_BURST;
                rd_idx_d   = head_q;
                rem_d      = grant;
                grant_d    = grant;
                fill_end_d = fill_q;
                if (req_i.req_type == brb_pkg::REQ_READ) begin
                  fill_end_d = fill_q - CNT_W'(grant);
                  fill_d     = fill_q - CNT_W'(grant);
                  head_d     = PTR_W'(head_adv);
                end
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end else if (cfg_we && (fill_q == '0)) begin
          cap_d  = pwdata[brb_pkg::CAP_W-1:0];
          head_d = '0;
          tail_d = '0;
        end
      end
      ST_BURST: begin
        out_valid_d          = 1'b1;
        out_ram_d            = 1'b1;
        out_d.read_byte      = '0;
        out_d.byte_valid     = 1'b1;
        out_d.write_accepted = 1'b0;
        out_d.granted_count  = grant_q;
        out_d.fill_after     = brb_pkg::FILL_W'(fill_end_q);
        out_d.last_of_run    = (rem_q == BURST_W'(1));
        rd_idx_d             = PTR_W'(rd_inc);
        rem_d                = rem_q - BURST_W'(1);
        if (rem_q == BURST_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= brb_pkg::CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_ram_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      out_ram_q   <= out_ram_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    grant_q    <= grant_d;
    fill_end_q <= fill_end_d;
    out_q      <= out_d;
  end

  // Byte store.
  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (brb_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (req_i.data_byte),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Result transaction: burst bytes come straight from the RAM read register.
  always_comb begin
    result_o = out_q;
    if (out_ram_q) begin
      result_o.read_byte = ram_rdata;
    end
  end

  assign result_valid_o = out_valid_q;
  assign busy           = (state_q == ST_BURST);

  // Register readback.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == brb_pkg::REG_CAPACITY) ? brb_pkg::PDATA_W'(cap_q) : '0;

endmodule

// ===== rtl/brb_checker.sv =====
// Port-level checker for the byte ring buffer, bound to the top level.
// Depends on brb_pkg and byte_ring_buffer_defines.svh.
`include "byte_ring_buffer_defines.svh"

module brb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input brb_pkg::req_t    req_i,
  input logic             result_valid_o,
  input brb_pkg::result_t result_o
);

  logic acc_write;
  logic acc_empty_burst;
  logic mid_run;
  logic write_result;
  logic run_end;
  logic no_data;

  assign acc_write       = start && !busy && (req_i.req_type == brb_pkg::REQ_WRITE);
  assign acc_empty_burst = start && !busy && (req_i.burst_len == '0) &&
                           ((req_i.req_type == brb_pkg::REQ_READ) ||
                            (req_i.req_type == brb_pkg::REQ_PEEK));
  assign mid_run         = result_valid_o && !result_o.last_of_run;
  assign write_result    = result_valid_o && result_o.write_accepted;
  assign run_end         = result_valid_o && result_o.last_of_run;
  assign no_data         = !result_o.byte_valid && (result_o.read_byte == '0);

  // A write transaction answers with one final result in the next cycle.
  `BRB_ASSERT(a_write_single, acc_write |=> run_end, "write result missing")
  // A burst with zero length answers with one empty final result.
  `BRB_ASSERT(a_empty_burst, acc_empty_burst |=> run_end && no_data, "empty burst result wrong")
  // While a run still has results to come, no new request can be taken.
  `BRB_ASSERT(a_run_busy, mid_run |-> busy && result_o.byte_valid, "run interrupted")
  // A stored write never carries a data byte.
  `BRB_ASSERT(a_write_fields, write_result |-> no_data, "write result carries data")
  // Reset leaves no result pending and the sequencer free.
  `BRB_ASSERT_RST(a_reset_clear, !rst_ni |=> !result_valid_o && !busy, "state not cleared by reset")

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ===== test/brb_test_pkg.sv =====
`timescale 1ns / 100ps
// Constants shared by the byte ring buffer testbench and its checker.
// Depends on brb_pkg for the field and port widths.
package brb_test_pkg;
  import brb_pkg::*;

  // Request code with no defined operation; the block answers it with a single result.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // Byte address of the capacity register on the configuration port.
  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * int'(REG_CAPACITY));

endpackage

// ===== test/byte_ring_buffer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the byte ring buffer: models the ring, predicts every result and compares.
// Depends on brb_pkg and brb_test_pkg; watches the request, result and register ports.
module byte_ring_buffer_checker
  import brb_pkg::*;
  import brb_test_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  req_t               req_i,
  input  logic               result_valid_i,
  input  result_t            result_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  input  logic [PDATA_W-1:0] prdata_i,
  input  logic               pready_i,
  output int                 mismatches_o,
  output int                 outstanding_o,
  output int                 results_seen_o
);

  // Model of the ring and its pointers.
  logic [BYTE_W-1:0] ring_bytes [STORE_DEPTH];
  int unsigned       head_pos;
  int unsigned       tail_pos;
  int unsigned       fill_count;
  logic [CAP_W-1:0]  capacity_reg;

  // Results predicted but not yet seen, oldest first.
  result_t expected_results [$];

  int mismatch_count = 0;
  int result_count   = 0;

  initial begin
    mismatches_o   = 0;
    outstanding_o  = 0;
    results_seen_o = 0;
  end

  // One line per mismatch; printing stops after a while so a broken block cannot flood the log.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // The capacity actually used: zero acts as one, anything past the store acts as its depth.
  function automatic int unsigned effective_capacity();
    int unsigned c;
    c = capacity_reg;
    if (c == 0) c = 1;
    if (c > STORE_DEPTH) c = STORE_DEPTH;
    return c;
  endfunction

  function automatic result_t make_result(input logic [BYTE_W-1:0] data, input logic valid,
                                          input logic accepted, input int unsigned granted,
                                          input int unsigned fill, input logic last);
    result_t r;
    r.read_byte      = data;
    r.byte_valid     = valid;
    r.write_accepted = accepted;
    r.granted_count  = BURST_W'(granted);
    r.fill_after     = FILL_W'(fill);
    r.last_of_run    = last;
    return r;
  endfunction

  // Work out the results of one accepted request and update the ring.
  task automatic predict_request(input req_t r);
    int unsigned cap_now;
    int unsigned granted;
    int unsigned fill_end;
    int unsigned slot;
    int unsigned k;
    cap_now = effective_capacity();
    case (r.req_type)
      REQ_WRITE: begin
        if (fill_count >= cap_now) begin
          // Full: the byte is dropped.
          expected_results.push_back(make_result('0, 1'b0, 1'b0, 0, fill_count, 1'b1));
        end else begin
          if (tail_pos >= cap_now) tail_pos = 0;
          ring_bytes[tail_pos] = r.data_byte;
          tail_pos++;
          if (tail_pos >= cap_now) tail_pos = 0;
          fill_count++;
          expected_results.push_back(make_result('0, 1'b0, 1'b1, 1, fill_count, 1'b1));
        end
      end
      REQ_READ, REQ_PEEK: begin
        granted = r.burst_len;
        if (granted > MAX_BURST) granted = MAX_BURST;
        if (granted > fill_count) granted = fill_count;
        if (granted == 0) begin
          expected_results.push_back(make_result('0, 1'b0, 1'b0, 0, fill_count, 1'b1));
        end else begin
          if (head_pos >= cap_now) head_pos = 0;
          fill_end = (r.req_type == REQ_READ) ? fill_count - granted : fill_count;
          for (k = 0; k < granted; k++) begin
            slot = head_pos + k;
            if (slot >= cap_now) slot -= cap_now;
            expected_results.push_back(make_result(ring_bytes[slot], 1'b1, 1'b0, granted,
                                                   fill_end, k + 1 == granted));
          end
          // Only a read consumes what it returned.
          if (r.req_type == REQ_READ) begin
            head_pos += granted;
            if (head_pos >= cap_now) head_pos -= cap_now;
            fill_count = fill_end;
          end
        end
      end
      default: begin
        expected_results.push_back(make_result('0, 1'b0, 1'b0, 0, fill_count, 1'b1));
      end
    endcase
  endtask

  // Compare one result with the oldest prediction, field by field.
  task automatic check_result(input result_t got);
    result_t want;
    string   bad;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = expected_results.pop_front();
    bad  = "";
    if (got.read_byte      !== want.read_byte)      bad = {bad, " read_byte"};
    if (got.byte_valid     !== want.byte_valid)     bad = {bad, " byte_valid"};
    if (got.write_accepted !== want.write_accepted) bad = {bad, " write_accepted"};
    if (got.granted_count  !== want.granted_count)  bad = {bad, " granted_count"};
    if (got.fill_after     !== want.fill_after)     bad = {bad, " fill_after"};
    if (got.last_of_run    !== want.last_of_run)    bad = {bad, " last_of_run"};
    if (bad != "") begin
      report_mismatch($sformatf("result %0d wrong in%s: got %h, want %h",
                                result_count, bad, got, want));
    end
    result_count++;
  endtask

  // The capacity is taken only while the ring is empty, and the pointers restart at zero.
  task automatic apply_register_write(input logic [PADDR_W-1:0] addr,
                                      input logic [PDATA_W-1:0] data);
    if (addr == CAP_ADDR && fill_count == 0) begin
      capacity_reg = data[CAP_W-1:0];
      head_pos     = 0;
      tail_pos     = 0;
    end
  endtask

  // Everything is sampled at the rising edge, with the values from before the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_pos     = 0;
      tail_pos     = 0;
      fill_count   = 0;
      capacity_reg = CAP_RESET;
      expected_results.delete();
    end else begin
      if (result_valid_i) check_result(result_i);
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          apply_register_write(paddr_i, pwdata_i);
        end else if (paddr_i == CAP_ADDR && prdata_i !== PDATA_W'(capacity_reg)) begin
          report_mismatch($sformatf("capacity read as %0d, expected %0d",
                                    prdata_i, capacity_reg));
        end
      end
      if (start_i && !busy_i) predict_request(req_i);
    end
    mismatches_o   <= mismatch_count;
    outstanding_o  <= expected_results.size();
    results_seen_o <= result_count;
  end

endmodule

// ===== test/byte_ring_buffer_test.sv =====
`timescale 1ns / 100ps
// Top of the byte ring buffer testbench: clock, reset, request and register stimulus, verdict.
// Depends on brb_pkg, brb_test_pkg, byte_ring_buffer and byte_ring_buffer_checker.
module byte_ring_buffer_test;
  import brb_pkg::*;
  import brb_test_pkg::*;

  localparam int RANDOM_PER_PHASE = 40;
  localparam int GAP_PERCENT      = 21;

  logic               clk_i;
  logic               rst_ni   = 1'b0;
  logic               start    = 1'b0;
  logic               busy;
  req_t               req_word = '0;
  logic               result_valid;
  result_t            result_word;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int outstanding;
  int results_seen;
  int requests_sent  = 0;
  int settings_used  = 0;
  bit gaps_enabled   = 1'b1;

  byte_ring_buffer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_word),
    .result_valid_o (result_valid),
    .result_o       (result_word),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  byte_ring_buffer_checker ring_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req_word),
    .result_valid_i (result_valid),
    .result_i       (result_word),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .results_seen_o (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t make_request(input logic [REQ_W-1:0] kind,
                                        input logic [BYTE_W-1:0] data,
                                        input logic [BURST_W-1:0] burst);
    req_t r;
    r.req_type  = kind;
    r.data_byte = data;
    r.burst_len = burst;
    return r;
  endfunction

  // Random request; mostly short bursts, some up to the limit and some past it.
  function automatic req_t random_request(input int write_pct);
    int sel;
    int len_sel;
    req_t r;
    sel     = $urandom_range(0, 99);
    len_sel = $urandom_range(0, 99);
    r.data_byte = BYTE_W'($urandom_range(0, 255));
    if (len_sel < 65) r.burst_len = BURST_W'($urandom_range(0, 6));
    else if (len_sel < 90) r.burst_len = BURST_W'($urandom_range(0, MAX_BURST));
    else r.burst_len = BURST_W'($urandom_range(MAX_BURST + 1, 127));
    if (sel < write_pct) r.req_type = REQ_WRITE;
    else if (sel >= 95) r.req_type = REQ_UNKNOWN;
    else if (sel >= 80) r.req_type = REQ_PEEK;
    else r.req_type = REQ_READ;
    return r;
  endfunction

  // Present one request and hold it until the block takes it; then idle a random
  // number of cycles, each idle cycle drawn on its own.
  task automatic issue_request(input req_t r);
    req_word <= r;
    start    <= 1'b1;
    do @(posedge clk_i); while (busy);
    requests_sent++;
    while (gaps_enabled && $urandom_range(0, 99) < GAP_PERCENT) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // One register transaction: setup cycle, then access until pready, then idle with psel low.
  task automatic apb_access(input logic write_en, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let the block go idle, then write the capacity and read it back.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
    repeat (3) @(posedge clk_i);
    apb_access(1'b1, CAP_ADDR, PDATA_W'(value));
    apb_access(1'b0, CAP_ADDR, '0);
    settings_used++;
  endtask

  // Enough full-length reads to empty the largest ring.
  task automatic drain_ring();
    repeat (STORE_DEPTH / MAX_BURST) begin
      issue_request(make_request(REQ_READ, BYTE_W'($urandom_range(0, 255)), MAX_BURST));
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [7];
    int phase;
    phase_caps    = '{9'd1, 9'd511, 9'd3, 9'd17, 9'd300, 9'd256, 9'd0};
    phase_caps[6] = CAP_W'($urandom_range(2, 511));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, CAP_ADDR, '0);

    // Empty ring: zero grants and an unknown request with every input bit set.
    issue_request(make_request(REQ_PEEK, 8'h00, 7'd0));
    issue_request(make_request(REQ_READ, 8'h00, 7'd5));
    issue_request(make_request(REQ_UNKNOWN, 8'hFF, 7'd127));
    // Field extremes on writes, then an oversized peek and a partial read.
    issue_request(make_request(REQ_WRITE, 8'h00, 7'd0));
    issue_request(make_request(REQ_WRITE, 8'hFF, 7'd127));
    issue_request(make_request(REQ_WRITE, 8'hA5, 7'd64));
    issue_request(make_request(REQ_PEEK, 8'h00, 7'd127));
    issue_request(make_request(REQ_READ, 8'h00, 7'd2));
    issue_request(make_request(REQ_READ, 8'h00, 7'd0));
    issue_request(make_request(REQ_UNKNOWN, 8'h00, 7'd0));
    issue_request(make_request(REQ_WRITE, 8'h5A, 7'd1));
    // A capacity write while bytes are held must be ignored.
    set_capacity(9'd3);
    issue_request(make_request(REQ_READ, 8'h00, 7'd64));
    // Capacity zero acts as one slot: fill, drop when full, wrap.
    set_capacity(9'd0);
    issue_request(make_request(REQ_WRITE, 8'h11, 7'd0));
    issue_request(make_request(REQ_WRITE, 8'h22, 7'd0));
    issue_request(make_request(REQ_UNKNOWN, 8'h00, 7'd3));
    issue_request(make_request(REQ_PEEK, 8'h00, 7'd1));
    issue_request(make_request(REQ_READ, 8'h00, 7'd1));
    issue_request(make_request(REQ_WRITE, 8'h33, 7'd0));
    issue_request(make_request(REQ_READ, 8'h00, 7'd64));

    // Random phases, each under its own capacity; now and then the ring is left
    // non-empty so the capacity write is refused. Phase three runs without pauses.
    for (phase = 0; phase < 7; phase++) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) drain_ring();
      set_capacity(phase_caps[phase]);
      gaps_enabled = (phase != 3);
      repeat (RANDOM_PER_PHASE) issue_request(random_request((phase % 2 == 1) ? 45 : 65));
    end

    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d requests under %0d capacity settings and checked %0d results.",
             requests_sent, settings_used, results_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
